### hw/rtl/rbf3_pkg.sv
// Shared constants, payload types and the weight table generator for the
// 3x3 range-only bilateral filter. No dependencies.
`default_nettype none

package rbf3_pkg;

	typedef logic [15:0] pixel_t;
	typedef logic [9:0]  coord_t;
	typedef logic [1:0]  cfg_index_t;
	typedef logic [15:0] cfg_data_t;

	// register indexes on the configuration channel
	localparam cfg_index_t CFG_FRAME_WIDTH  = 2'd0;
	localparam cfg_index_t CFG_FRAME_HEIGHT = 2'd1;
	localparam cfg_index_t CFG_RANGE_SCALE  = 2'd2;
	// index with no register behind it; writes there are ignored
	localparam cfg_index_t CFG_UNUSED       = 2'd3;

	// input word kinds
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// register reset values
	localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [10:0] FRAME_HEIGHT_RST = 11'd480;
	localparam logic [15:0] RANGE_SCALE_RST  = 16'd22756;

	// default sizes
	localparam int MAX_WIDTH_DEF    = 1024;
	localparam int MAX_HEIGHT_DEF   = 1024;
	localparam int WEIGHT_DEPTH_DEF = 256;

	// exp(-1/16) in Q60
	localparam logic [63:0] DECAY_Q60 = 64'd1083069521826238951;

	// round(65535 * exp(-idx/16)), built by repeated Q60 decay steps
	function automatic pixel_t weight_at(input int idx);
		logic [63:0]  v;
		logic [127:0] prod;
		v = 64'd1 << 60;
		for (int i = 0; i < idx; i++) begin
			prod = {64'd0, v} * {64'd0, DECAY_Q60};
			v = prod[123:60];
		end
		prod = {64'd0, v} * 128'd65535 + (128'd1 << 59);
		return prod[75:60];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rbf3_if.sv
// Valid/ready channel interfaces of the bilateral filter: pixel input,
// filtered result output and register writes. Uses rbf3_pkg.
`default_nettype none

interface rbf3_in_if;
	logic            valid;
	logic            ready;
	logic            action;
	rbf3_pkg::pixel_t pixel_value;
	modport source (output valid, action, pixel_value, input ready);
	modport sink   (input valid, action, pixel_value, output ready);
endinterface

interface rbf3_out_if;
	logic             valid;
	logic             ready;
	rbf3_pkg::pixel_t filtered_value;
	rbf3_pkg::coord_t out_row;
	rbf3_pkg::coord_t out_col;
	logic             frame_last;
	modport source (output valid, filtered_value, out_row, out_col, frame_last, input ready);
	modport sink   (input valid, filtered_value, out_row, out_col, frame_last, output ready);
endinterface

interface rbf3_cfg_if;
	logic                 valid;
	logic                 ready;
	rbf3_pkg::cfg_index_t index;
	rbf3_pkg::cfg_data_t  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/range_bilateral_filter_3x3_core.sv
// Top level of the 3x3 range-only bilateral filter: line store memory,
// window fetch, weighting pipeline and serial divider. Uses rbf3_pkg, rbf3_if.
//
// Usage:
//   pix_in  : words in raster order; action = pixel writes a pixel, action =
//             flush drains one pending result if its neighbors are all in.
//   res_out : filtered pixel with its row, column and frame_last flag.
//   cfg     : register writes (width, height, range scale), always ready;
//             each register write restarts the stream and drops pending pixels.
// Flow: a word that yields no result leaves pix_in.ready high. A word that
//   yields a result holds pix_in.ready low while the nine window pixels
//   are fetched through the single read port of the line store, go through
//   the weighting pipeline and the one bit per cycle divider (16 quotient
//   bits), and the output register is loaded; res_out.valid rises when the
//   output register is loaded. A pixel is given once the pixel width+1
//   places later has arrived.
// The output register holds a finished word while res_out.ready is low;
//   new input is taken meanwhile, and the next result waits in the divider
//   until the output register frees up, holding pix_in.ready low.
// Reset clears counters and control; the line store is not cleared, as no
//   entry is used before the stream writes it.
`default_nettype none

module range_bilateral_filter_3x3_core #(
	parameter int MAX_WIDTH          = rbf3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT         = rbf3_pkg::MAX_HEIGHT_DEF,
	parameter int WEIGHT_TABLE_DEPTH = rbf3_pkg::WEIGHT_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	rbf3_in_if.sink     pix_in,
	rbf3_out_if.source  res_out,
	rbf3_cfg_if.sink    cfg
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int PW = $clog2(MAX_WIDTH + 3) + 1;
	localparam int IW = $clog2(WEIGHT_TABLE_DEPTH);
	localparam int AW = CW + 2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_PROC = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// weight table as constant logic
	rbf3_pkg::pixel_t wrom [WEIGHT_TABLE_DEPTH];
	for (genvar g = 0; g < WEIGHT_TABLE_DEPTH; g++) begin : g_rom
		localparam rbf3_pkg::pixel_t WV = rbf3_pkg::weight_at(g);
		assign wrom[g] = WV;
	end

	// registers
	logic [10:0] frame_width_q, frame_height_q;
	logic [15:0] range_scale_q;

	logic [CW-1:0] in_col_q, em_col_q, cur_col_q;
	logic [1:0]    in_slot_q, em_slot_q, cur_slot_q;
	logic [RW-1:0] em_row_q, cur_row_q;
	logic [PW-1:0] pend_q;
	logic          cur_last_q;
	logic [8:0]    ok_q;

	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic [1:0] ld_r_q, ld_c_q;
	logic [3:0] wr_k_q;
	logic       wr_v_q;

	rbf3_pkg::pixel_t mem [1 << AW];
	rbf3_pkg::pixel_t rd_q;
	rbf3_pkg::pixel_t win_q [9];

	logic             v_s1, v_s2, v_s3, v_s4;
	logic [31:0]      d2_s1;
	logic [47:0]      sc_s2;
	rbf3_pkg::pixel_t p_s1, p_s2, p_s3, wt_s3, wt_s4;
	logic [31:0]      wp_s4;

	logic [35:0] num_q, rem_q, dsh_q;
	logic [19:0] den_q;
	logic [15:0] quo_q;

	logic             out_valid_q;
	rbf3_pkg::pixel_t out_val_q;
	rbf3_pkg::coord_t out_row_q, out_col_q;
	logic             out_last_q;

	// effective frame size
	logic [CW:0] w_eff;
	logic [RW:0] h_eff;
	logic [31:0] wtmp, htmp;
	always_comb begin
		if (frame_width_q == 11'd0) begin
			wtmp = 32'd1;
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			wtmp = 32'(MAX_WIDTH);
		end else begin
			wtmp = 32'(frame_width_q);
		end
		if (frame_height_q == 11'd0) begin
			htmp = 32'd1;
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			htmp = 32'(MAX_HEIGHT);
		end else begin
			htmp = 32'(frame_height_q);
		end
		w_eff = wtmp[CW:0];
		h_eff = htmp[RW:0];
	end

	// accept and result decision
	logic acc, is_pix, cfg_wr, cfg_take, emit_now;
	logic row_lo_ok, row_hi_ok, col_lo_ok, col_hi_ok;
	logic [PW-1:0] need;
	logic [CW:0] in_col_inc, em_col_inc;
	logic [RW:0] em_row_inc;

	assign pix_in.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign acc    = pix_in.valid && pix_in.ready;
	assign is_pix = (pix_in.action == rbf3_pkg::ACT_PIXEL);
	assign cfg_wr = cfg.valid && cfg.ready;
	// a write that lands on a register and restarts the stream
	assign cfg_take = cfg_wr && (cfg.index != rbf3_pkg::CFG_UNUSED);

	assign in_col_inc = {1'b0, in_col_q} + 1'b1;
	assign em_col_inc = {1'b0, em_col_q} + 1'b1;
	assign em_row_inc = {1'b0, em_row_q} + 1'b1;
	assign row_lo_ok  = (em_row_q != '0);
	assign row_hi_ok  = (em_row_inc < h_eff);
	assign col_lo_ok  = (em_col_q != '0);
	assign col_hi_ok  = (em_col_inc < w_eff);

	always_comb begin
		need = PW'(1) + (row_hi_ok ? PW'(w_eff) : '0) + (col_hi_ok ? PW'(1) : '0);
		if (is_pix) begin
			emit_now = (pend_q + PW'(1)) >= (PW'(w_eff) + PW'(2));
		end else begin
			emit_now = pend_q >= need;
		end
	end

	// registers and stream counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rbf3_pkg::FRAME_WIDTH_RST;
			frame_height_q <= rbf3_pkg::FRAME_HEIGHT_RST;
			range_scale_q  <= rbf3_pkg::RANGE_SCALE_RST;
			in_col_q  <= '0;
			in_slot_q <= '0;
			em_row_q  <= '0;
			em_col_q  <= '0;
			em_slot_q <= '0;
			pend_q    <= '0;
		end else if (cfg_take) begin
			unique case (cfg.index)
				rbf3_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg.data[10:0];
				rbf3_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg.data[10:0];
				default:                    range_scale_q  <= cfg.data;
			endcase
			in_col_q  <= '0;
			in_slot_q <= '0;
			em_row_q  <= '0;
			em_col_q  <= '0;
			em_slot_q <= '0;
			pend_q    <= '0;
		end else if (acc) begin
			if (is_pix) begin
				if (in_col_inc >= w_eff) begin
					in_col_q  <= '0;
					in_slot_q <= in_slot_q + 2'd1;
				end else begin
					in_col_q <= in_col_inc[CW-1:0];
				end
			end
			if (emit_now) begin
				if (em_col_inc >= w_eff) begin
					em_col_q  <= '0;
					em_slot_q <= em_slot_q + 2'd1;
					em_row_q  <= (em_row_inc >= h_eff) ? '0 : em_row_inc[RW-1:0];
				end else begin
					em_col_q <= em_col_inc[CW-1:0];
				end
			end
			pend_q <= pend_q + (is_pix ? PW'(1) : '0) - (emit_now ? PW'(1) : '0);
		end
	end

	// line store: four row slots, one write and one registered read port
	logic [AW-1:0] rd_addr;
	logic [1:0]    rd_slot;
	logic [CW-1:0] rd_col;
	assign rd_slot = cur_slot_q + 2'd3 + ld_r_q;
	assign rd_col  = cur_col_q + CW'(ld_c_q) - CW'(1);
	assign rd_addr = {rd_slot, rd_col};

	always_ff @(posedge clk) begin
		if (acc && is_pix) begin
			mem[{in_slot_q, in_col_q}] <= pix_in.pixel_value;
		end
		rd_q <= mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ld_r_q  <= '0;
			ld_c_q  <= '0;
			wr_v_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && emit_now && !cfg_take) begin
						state_q <= ST_LOAD;
						cnt_q   <= '0;
						ld_r_q  <= '0;
						ld_c_q  <= '0;
					end
				end
				ST_LOAD: begin
					wr_v_q <= (cnt_q < 5'd9);
					if (cnt_q < 5'd9) begin
						if (ld_c_q == 2'd2) begin
							ld_c_q <= '0;
							ld_r_q <= ld_r_q + 2'd1;
						end else begin
							ld_c_q <= ld_c_q + 2'd1;
						end
					end
					if (cnt_q == 5'd9) begin
						state_q <= ST_PROC;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_PROC: begin
					if (cnt_q == 5'd13) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == 5'd16) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || res_out.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// latch position and neighbor mask of the pixel being given
	always_ff @(posedge clk) begin
		if (acc && emit_now) begin
			cur_row_q  <= em_row_q;
			cur_col_q  <= em_col_q;
			cur_slot_q <= em_slot_q;
			cur_last_q <= (em_row_inc == h_eff) && (em_col_inc == w_eff);
			ok_q <= {row_hi_ok & col_hi_ok, row_hi_ok, row_hi_ok & col_lo_ok,
				col_hi_ok, 1'b1, col_lo_ok,
				row_lo_ok & col_hi_ok, row_lo_ok, row_lo_ok & col_lo_ok};
		end
		wr_k_q <= {1'b0, ld_r_q, 1'b0} + {2'b00, ld_r_q} + {2'b00, ld_c_q};
		if (wr_v_q) begin
			win_q[wr_k_q] <= rd_q;
		end
	end

	// weighting pipeline: square, scale, table, product, accumulate
	logic [3:0]       k_sel;
	rbf3_pkg::pixel_t p_sel, dif;
	logic [27:0]      ix_raw;
	logic [IW-1:0]    ix;
	assign k_sel  = (cnt_q < 5'd9) ? cnt_q[3:0] : 4'd0;
	assign p_sel  = win_q[k_sel];
	assign dif    = (p_sel >= win_q[4]) ? p_sel - win_q[4] : win_q[4] - p_sel;
	assign ix_raw = sc_s2[47:20];
	assign ix     = (ix_raw > 28'(WEIGHT_TABLE_DEPTH - 1)) ?
		IW'(WEIGHT_TABLE_DEPTH - 1) : ix_raw[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_PROC) && (cnt_q < 5'd9) && ok_q[k_sel];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		d2_s1 <= dif * dif;
		p_s1  <= p_sel;
		sc_s2 <= {16'd0, d2_s1} * {32'd0, range_scale_q};
		p_s2  <= p_s1;
		wt_s3 <= wrom[ix];
		p_s3  <= p_s2;
		wp_s4 <= wt_s3 * p_s3;
		wt_s4 <= wt_s3;
		if (state_q == ST_LOAD) begin
			num_q <= '0;
			den_q <= '0;
		end else if (state_q == ST_PROC && v_s4) begin
			num_q <= num_q + 36'(wp_s4);
			den_q <= den_q + 20'(wt_s4);
		end
	end

	// restoring divider, one quotient bit per cycle
	logic div_ge;
	assign div_ge = (rem_q >= dsh_q);
	always_ff @(posedge clk) begin
		if (state_q == ST_PROC) begin
			rem_q <= num_q;
			dsh_q <= 36'(den_q) << 15;
			quo_q <= '0;
		end else if (state_q == ST_DIV && cnt_q < 5'd16) begin
			if (div_ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[14:0], div_ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	// output register
	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || res_out.ready);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_val_q  <= quo_q;
			out_row_q  <= 10'(cur_row_q);
			out_col_q  <= 10'(cur_col_q);
			out_last_q <= cur_last_q;
		end
	end

	assign res_out.valid          = out_valid_q;
	assign res_out.filtered_value = out_val_q;
	assign res_out.out_row        = out_row_q;
	assign res_out.out_col        = out_col_q;
	assign res_out.frame_last     = out_last_q;

	// checks
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(w_eff) + PW'(1))
		else $error("pending count above width + 1");

	a_busy_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && emit_now && !cfg_take) |=> !pix_in.ready)
		else $error("input taken while a result is in progress");

	a_div_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == 5'd0) |-> (rem_q < (36'(den_q) << 16)))
		else $error("quotient exceeds pixel range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_out.ready) |=> (out_valid_q && $stable(out_val_q)))
		else $error("stalled result changed");

endmodule

`default_nettype wire
